[hdl/ssd_pkg.sv]
`default_nettype none

package ssd_pkg;

  localparam int VALUE_W     = 32;
  localparam int SYM_W       = 4;
  localparam int DIGIT_W     = 4;
  localparam int CFG_W       = 4;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 8;
  // 2^31 needs ten decimal digits
  localparam int BCD_DIGITS  = 10;
  localparam int POS_W       = $clog2(BCD_DIGITS);
  localparam int BIT_CNT_W   = $clog2(VALUE_W);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [BCD_DIGITS-1:0] bcd_t;
  typedef logic [SYM_W-1:0] sym_t;

  localparam sym_t SYM_MINUS = 4'd10;
  localparam sym_t SYM_O     = 4'd11;
  localparam sym_t SYM_F     = 4'd12;
  localparam sym_t SYM_BLANK = 4'd13;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

  typedef struct packed {
    logic done;
    bcd_t digits;
  } bcd_stat_t;

endpackage

`default_nettype wire

[hdl/ssd_bcd.sv]
`default_nettype none

// Serial double-dabble: one magnitude bit enters the BCD register per cycle.
module ssd_bcd import ssd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VALUE_W-1:0] mag_i,
  output bcd_stat_t          stat_o
);

  logic [VALUE_W-1:0]   mag_q, mag_d;
  bcd_t                 digits_q, digits_d;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  bcd_t                 adj;
  logic [BCD_DIGITS*DIGIT_W:0] shifted;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i] = (digits_q[i] >= 4'd5) ? digits_q[i] + 4'd3 : digits_q[i];
    end
    shifted = {adj, mag_q[VALUE_W-1]};

    mag_d    = mag_q;
    digits_d = digits_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      mag_d    = mag_i;
      digits_d = '0;
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      mag_d    = {mag_q[VALUE_W-2:0], 1'b0};
      digits_d = bcd_t'(shifted[BCD_DIGITS*DIGIT_W-1:0]);
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    digits_q <= digits_d;
  end

  assign stat_o.done   = done_q;
  assign stat_o.digits = digits_q;

endmodule

`default_nettype wire

[hdl/ssd_emit.sv]
`default_nettype none

// Sequencer: range check, leading-zero skip and symbol emission into the output register.
module ssd_emit import ssd_pkg::*; #(
  parameter int MAX_DIGITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic             func_i,
  input  logic             neg_i,
  input  logic [CFG_W-1:0] cfg_count_i,
  output logic             start_o,
  input  bcd_stat_t        bcd_stat_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output sym_t             sym_o,
  output logic             last_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CONV  = 8'b0000_0010,
    S_SKIP  = 8'b0000_0100,
    S_SIGN  = 8'b0000_1000,
    S_DIGIT = 8'b0001_0000,
    S_OVF_O = 8'b0010_0000,
    S_OVF_F = 8'b0100_0000,
    S_BLANK = 8'b1000_0000
  } state_e;

  localparam logic [CFG_W-1:0] MaxCount = CFG_W'(MAX_DIGITS);

  state_e           state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             neg_q, neg_d;
  logic             m_valid_q, m_valid_d;
  sym_t             sym_q, sym_d;
  logic             last_q, last_d;
  logic [CFG_W-1:0] n_eff, lim;
  logic             ovf;
  logic             out_free;
  digit_t           cur;

  always_comb begin
    if (cfg_count_i == '0) begin
      n_eff = CFG_W'(1);
    end else if (cfg_count_i > MaxCount) begin
      n_eff = MaxCount;
    end else begin
      n_eff = cfg_count_i;
    end
    // a minus sign takes one position
    lim = neg_q ? n_eff - 1'b1 : n_eff;
    ovf = 1'b0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if ((CFG_W'(i) >= lim) && (bcd_stat_i.digits[i] != '0)) begin
        ovf = 1'b1;
      end
    end
  end

  assign cur      = bcd_stat_i.digits[pos_q];
  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    neg_d     = neg_q;
    m_valid_d = m_valid_q && !m_ready_i;
    sym_d     = sym_q;
    last_d    = last_q;
    start_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          neg_d = neg_i;
          if (func_i) begin
            state_d = S_BLANK;
          end else begin
            start_o = 1'b1;
            state_d = S_CONV;
          end
        end
      end
      S_CONV: begin
        if (bcd_stat_i.done) begin
          pos_d   = POS_W'(BCD_DIGITS - 1);
          state_d = ovf ? S_OVF_O : S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keep the units digit
        if ((cur == '0) && (pos_q != '0)) begin
          pos_d = pos_q - 1'b1;
        end else begin
          state_d = neg_q ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          sym_d     = SYM_MINUS;
          last_d    = 1'b0;
          state_d   = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          sym_d     = sym_t'(cur);
          last_d    = (pos_q == '0);
          if (pos_q == '0) begin
            state_d = S_IDLE;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      S_OVF_O: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          sym_d     = SYM_O;
          last_d    = 1'b0;
          state_d   = S_OVF_F;
        end
      end
      S_OVF_F: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          sym_d     = SYM_F;
          last_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_BLANK: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          sym_d     = SYM_BLANK;
          last_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_q     <= '0;
      neg_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      neg_q     <= neg_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    last_q <= last_d;
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;
  assign sym_o     = sym_q;
  assign last_o    = last_q;

endmodule

`default_nettype wire

[hdl/signed_decimal_display_sequencer.sv]
// Signed decimal display sequencer.
// Input stream: s_axis_tdata carries the signed 32-bit value, s_axis_tuser
// selects clear (1) or show value (0). A request is taken when tvalid and
// tready are both high; tready is high only while the block is idle.
// Output stream: one display symbol per transfer in m_axis_tdata[3:0]
// (0-9 digit, 10 minus, 11 O, 12 F, 13 blank), m_axis_tlast on the final
// symbol of a request. Symbols come most significant first.
// cfg_we_i writes cfg_wdata_i into the digit-count register (reset 4).
// With a ready receiver: a clear request passes to the blank state and
// loads its blank symbol from there. A show request runs a bit-serial
// binary-to-BCD conversion over all 32 magnitude bits, then picks overflow
// or digits; the overflow mark is the two symbols O and F, otherwise leading
// zeros are skipped and the minus sign, if any, and the digits are loaded.
// The next request is taken only after the last symbol of a request is
// loaded, and the 32-bit serial conversion mainly sets the request rate. A
// stalled receiver holds the output register and stops the sequencer; no
// symbol is dropped.
// Reset clears all control state and the output valid, and sets the digit
// count to 4.
`default_nettype none

module signed_decimal_display_sequencer import ssd_pkg::*; #(
  parameter int MAX_DIGITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,   // digit_count
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [31:0] value
  input  logic [0:0]             s_axis_tuser,  // [0] func
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // [3:0] symbol, [7:4] zero
  output logic                   m_axis_tlast
);

  logic [CFG_W-1:0]   cfg_q, cfg_d;
  logic [VALUE_W-1:0] mag;
  logic               start;
  bcd_stat_t          bcd_stat;
  sym_t               sym;

  assign cfg_d = cfg_we_i ? cfg_wdata_i : cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // unsigned magnitude; the most negative value maps to 2^31 exactly
  assign mag = s_axis_tdata[VALUE_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;

  ssd_bcd u_bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mag_i  (mag),
    .stat_o (bcd_stat)
  );

  ssd_emit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .func_i     (s_axis_tuser[0]),
    .neg_i      (s_axis_tdata[VALUE_W-1]),
    .cfg_count_i(cfg_q),
    .start_o    (start),
    .bcd_stat_i (bcd_stat),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .sym_o      (sym),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {(TDATA_OUT_W - SYM_W)'(0), sym};

endmodule

`default_nettype wire

[hdl/ssd_chk.sv]
`default_nettype none

module ssd_chk import ssd_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // hold a stalled symbol
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // when idle, a pending symbol can only be the final one of its request
  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("idle with a non-final symbol pending");

  // overflow mark ends with F, which is always final
  a_f_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tdata[SYM_W-1:0] == SYM_O) |=>
      m_axis_tvalid && (m_axis_tdata[SYM_W-1:0] == SYM_F) && m_axis_tlast)
    else $error("overflow mark not followed by final F");

endmodule

bind signed_decimal_display_sequencer ssd_chk u_ssd_chk (.*);

`default_nettype wire

[tb/sv/tb_signed_decimal_display_sequencer.sv]
`default_nettype none

module tb_signed_decimal_display_sequencer;
  import ssd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_DIG     = 8;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          STALL_LEN   = 400;
  localparam int          TAIL_WAIT   = 60;
  localparam int          PHASE_ITEMS = 43;
  localparam logic        FUNC_SHOW   = 1'b0;
  localparam logic        FUNC_CLEAR  = 1'b1;

  typedef struct {
    logic              func;
    logic [VALUE_W-1:0] value;
  } disp_req_t;

  typedef struct {
    sym_t sym;
    logic last;
  } disp_sym_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  disp_req_t      req_q[$];
  disp_sym_t      symbol_q[$];
  logic [CFG_W-1:0] digit_cfg = CFG_RESET;
  int             err_cnt   = 0;
  int             cycle_cnt = 0;
  bit             idle_en   = 1'b1;
  bit             sink_hold = 1'b0;
  int             src_gap   = 0;
  int             snk_gap   = 0;
  disp_req_t      next_req;
  disp_sym_t      got_sym;

  signed_decimal_display_sequencer #(
    .MAX_DIGITS(MAX_DIG)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[signed_decimal_display_sequencer] ERROR");
      $finish;
    end
  end

  function automatic longint unsigned pow10(int unsigned n);
    longint unsigned p;
    p = 1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  // zero counts as one position, anything above the maximum saturates
  function automatic int unsigned eff_digits();
    int unsigned n;
    n = 32'(digit_cfg);
    if (n < 1) n = 1;
    if (n > MAX_DIG) n = MAX_DIG;
    return n;
  endfunction

  function automatic void push_symbol(sym_t s, logic l);
    disp_sym_t e;
    e.sym  = s;
    e.last = l;
    symbol_q.push_back(e);
  endfunction

  function automatic void predict_symbols(logic func, logic [VALUE_W-1:0] v);
    int unsigned     n;
    bit              neg;
    longint unsigned mag;
    longint unsigned lim;
    sym_t            dq[$];
    n = eff_digits();
    if (func == FUNC_CLEAR) begin
      push_symbol(SYM_BLANK, 1'b1);
      return;
    end
    neg = v[VALUE_W-1];
    mag = neg ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
    lim = neg ? pow10(n - 1) - 1 : pow10(n) - 1;
    if (mag > lim) begin
      push_symbol(SYM_O, 1'b0);
      push_symbol(SYM_F, 1'b1);
      return;
    end
    if (neg) push_symbol(SYM_MINUS, 1'b0);
    do begin
      dq.push_front(sym_t'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (dq[i]) push_symbol(dq[i], (i == dq.size() - 1));
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 20) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // driver: offer queued requests, predict on each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_symbols(s_axis_tuser[0], s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          if (idle_en && $urandom_range(0, 3) == 0) begin
            src_gap = $urandom_range(0, 4);
            s_axis_tvalid <= 1'b0;
          end else begin
            next_req = req_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= next_req.value;
            s_axis_tuser  <= next_req.func;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each symbol with the oldest prediction, throttle tready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (symbol_q.size() == 0) begin
          report_mismatch($sformatf("unexpected symbol tdata=%0h last=%b",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          got_sym = symbol_q.pop_front();
          if (m_axis_tdata !== TDATA_OUT_W'(got_sym.sym))
            report_mismatch($sformatf("symbol %0h, expected %0d",
                                      m_axis_tdata, got_sym.sym));
          if (m_axis_tlast !== got_sym.last)
            report_mismatch($sformatf("last %b, expected %b on symbol %0d",
                                      m_axis_tlast, got_sym.last, got_sym.sym));
        end
      end
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void add_request(logic func, logic [VALUE_W-1:0] v);
    disp_req_t r;
    r.func  = func;
    r.value = v;
    req_q.push_back(r);
  endfunction

  function automatic void add_random_request();
    int unsigned     sel;
    int unsigned     n;
    int unsigned     k;
    longint unsigned mag;
    bit              neg;
    n   = eff_digits();
    sel = $urandom_range(0, 19);
    neg = 1'($urandom_range(0, 1));
    if (sel == 0) begin
      add_request(FUNC_CLEAR, $urandom);
      return;
    end
    if (sel <= 3) begin
      add_request(FUNC_SHOW, $urandom);
      return;
    end
    if (sel <= 6) begin
      // straddle the range boundary
      mag = neg ? pow10(n - 1) - 1 : pow10(n) - 1;
      mag = mag + $urandom_range(0, 1);
    end else if (sel <= 11) begin
      // digit by digit with plenty of zeros
      k   = $urandom_range(1, n);
      mag = 0;
      repeat (k) mag = mag * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 9));
    end else begin
      k   = $urandom_range(1, n + 1);
      mag = 64'($urandom_range(0, int'(pow10(k) - 1)));
    end
    add_request(FUNC_SHOW, neg ? VALUE_W'(-mag) : VALUE_W'(mag));
  endfunction

  task automatic write_digit_count(logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    digit_cfg = v;
  endtask

  // returns at a falling edge once everything is accepted and every symbol is in
  task automatic wait_drained();
    @(negedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid || symbol_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [CFG_W-1:0] rand_cfg[10] = '{4'd9, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd1,
                                       4'd8, 4'd0, 4'd15};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset value of four positions
    @(negedge clk_i);
    add_request(FUNC_SHOW, 32'd0);
    add_request(FUNC_SHOW, 32'd1);
    add_request(FUNC_SHOW, 32'd9999);
    add_request(FUNC_SHOW, 32'd10000);
    add_request(FUNC_SHOW, -32'sd1);
    add_request(FUNC_SHOW, -32'sd999);
    add_request(FUNC_SHOW, -32'sd1000);
    add_request(FUNC_SHOW, 32'd1005);
    add_request(FUNC_SHOW, 32'h7FFF_FFFF);
    add_request(FUNC_SHOW, 32'h8000_0000);
    add_request(FUNC_CLEAR, 32'hFFFF_FFFF);
    add_request(FUNC_CLEAR, 32'd0);
    wait_drained();

    // one position: every negative overflows
    write_digit_count(4'd1);
    @(negedge clk_i);
    add_request(FUNC_SHOW, 32'd9);
    add_request(FUNC_SHOW, 32'd10);
    add_request(FUNC_SHOW, -32'sd1);
    wait_drained();

    write_digit_count(4'd8);
    @(negedge clk_i);
    add_request(FUNC_SHOW, 32'd99999999);
    add_request(FUNC_SHOW, 32'd100000000);
    add_request(FUNC_SHOW, -32'sd9999999);
    add_request(FUNC_SHOW, -32'sd10000000);
    add_request(FUNC_SHOW, 32'd10000001);
    wait_drained();

    // zero acts as one, fifteen saturates to eight
    write_digit_count(4'd0);
    @(negedge clk_i);
    add_request(FUNC_SHOW, 32'd7);
    add_request(FUNC_SHOW, -32'sd0);
    wait_drained();
    write_digit_count(4'd15);
    @(negedge clk_i);
    add_request(FUNC_SHOW, 32'd12345678);
    add_request(FUNC_SHOW, -32'sd1234567);
    wait_drained();

    foreach (rand_cfg[p]) begin
      write_digit_count(rand_cfg[p]);
      @(negedge clk_i);
      idle_en = !(p == 5 || p == 9);
      if (p == 3) begin
        // hold the receiver off while requests keep coming
        sink_hold = 1'b1;
        repeat (PHASE_ITEMS) add_random_request();
        repeat (STALL_LEN) @(negedge clk_i);
        sink_hold = 1'b0;
      end else begin
        repeat (PHASE_ITEMS) add_random_request();
      end
      wait_drained();
    end

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (symbol_q.size() != 0)
      report_mismatch($sformatf("%0d symbols never arrived", symbol_q.size()));
    if (err_cnt == 0)
      $display("[signed_decimal_display_sequencer] OK");
    else
      $display("[signed_decimal_display_sequencer] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/ssd_pkg.sv
hdl/ssd_bcd.sv
hdl/ssd_emit.sv
hdl/signed_decimal_display_sequencer.sv
hdl/ssd_chk.sv
tb/sv/tb_signed_decimal_display_sequencer.sv
